>>> hdl/assert_macros.svh
// Assertion helpers used by the checker module shbp_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/shbp_pkg.sv
// ----------------------------------------------------------------------------
// shbp_pkg
// Types, constants and the code table of the static prefix-code byte packer.
// ----------------------------------------------------------------------------
`default_nettype none

package shbp_pkg;

    localparam int CODE_MAX_LEN = 13;
    localparam int CODE_LEN_W   = 4;
    localparam int PEND_W       = 7;
    localparam int PEND_CNT_W   = 3;
    localparam int ACC_W        = PEND_W + CODE_MAX_LEN;

    typedef enum logic [0:0] {
        KIND_SYMBOL = 1'b0,
        KIND_FLUSH  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] symbol_char;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       symbol_unknown;
        logic       run_last;
    } out_item_t;

    // Code bits are stored first-bit-in-bit-0
    typedef struct packed {
        logic                    known;
        logic [CODE_LEN_W-1:0]   len;
        logic [CODE_MAX_LEN-1:0] bits;
    } code_t;

    function automatic code_t code_lookup(input logic [7:0] ch);
        code_t c;
        c = '0;
        c.known = 1'b1;
        unique case (ch)
            "a": begin c.len = 4'd3;  c.bits = 13'b001;           end
            "b": begin c.len = 4'd8;  c.bits = 13'b00011011;      end
            "c": begin c.len = 4'd10; c.bits = 13'b0010011011;    end
            "d": begin c.len = 4'd7;  c.bits = 13'b0001011;       end
            "e": begin c.len = 4'd4;  c.bits = 13'b0010;          end
            "f": begin c.len = 4'd7;  c.bits = 13'b1011011;       end
            "g": begin c.len = 4'd7;  c.bits = 13'b1001011;       end
            "h": begin c.len = 4'd6;  c.bits = 13'b110000;        end
            "i": begin c.len = 4'd3;  c.bits = 13'b110;           end
            "j": begin c.len = 4'd6;  c.bits = 13'b111011;        end
            "k": begin c.len = 4'd4;  c.bits = 13'b0101;          end
            "l": begin c.len = 4'd4;  c.bits = 13'b0011;          end
            "m": begin c.len = 4'd5;  c.bits = 13'b01101;         end
            "n": begin c.len = 4'd4;  c.bits = 13'b0100;          end
            "o": begin c.len = 4'd4;  c.bits = 13'b1010;          end
            "p": begin c.len = 4'd5;  c.bits = 13'b11101;         end
            "q": begin c.len = 4'd12; c.bits = 13'b101010011011;  end
            "r": begin c.len = 4'd5;  c.bits = 13'b00000;         end
            "s": begin c.len = 4'd4;  c.bits = 13'b1000;          end
            "t": begin c.len = 4'd3;  c.bits = 13'b111;           end
            "u": begin c.len = 4'd4;  c.bits = 13'b1100;          end
            "v": begin c.len = 4'd6;  c.bits = 13'b010000;        end
            "w": begin c.len = 4'd12; c.bits = 13'b001010011011;  end
            "x": begin c.len = 4'd13; c.bits = 13'b0011010011011; end
            "y": begin c.len = 4'd6;  c.bits = 13'b101011;        end
            "z": begin c.len = 4'd12; c.bits = 13'b111010011011;  end
            " ": begin c.len = 4'd9;  c.bits = 13'b110011011;     end
            "0": begin c.len = 4'd3;  c.bits = 13'b101;           end
            "1": begin c.len = 4'd3;  c.bits = 13'b110;           end
            "2": begin c.len = 4'd4;  c.bits = 13'b1000;          end
            "3": begin c.len = 4'd4;  c.bits = 13'b0100;          end
            "4": begin c.len = 4'd4;  c.bits = 13'b1100;          end
            "5": begin c.len = 4'd4;  c.bits = 13'b0000;          end
            "6": begin c.len = 4'd4;  c.bits = 13'b0010;          end
            "7": begin c.len = 4'd4;  c.bits = 13'b1010;          end
            "8": begin c.len = 4'd4;  c.bits = 13'b0001;          end
            "9": begin c.len = 4'd5;  c.bits = 13'b01001;         end
            ",": begin c.len = 4'd2;  c.bits = 13'b11;            end
            default: c.known = 1'b0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/static_huffman_byte_packer.sv
// ----------------------------------------------------------------------------
// static_huffman_byte_packer
// Encodes ASCII characters with a fixed variable-length code and packs the
// bits into bytes, first code bit in bit 0.
// ----------------------------------------------------------------------------
// Usage:
//   item_* : input channel (valid/ready). kind selects encode or flush.
//   res_*  : result channel (valid/ready). Each result is a packed byte, or
//            a single unknown-character marker with symbol_unknown set.
//   An encoded character yields 0, 1 or 2 bytes; a flush yields one padded
//   byte if bits are pending, else nothing. run_last marks the final result
//   of an item.
// Path: an accepted item passes the input register, then is encoded into
//   the 2-entry result queue once it has room; its first result is offered
//   from the head of the queue.
// Throughput: one item per cycle as long as the result channel drains; an
//   item producing two bytes needs two result transfers, so long codes
//   lower the item rate, bounded by the single result port.
// Reset: empties the bit accumulator, the input register and the queue.
// Stall: when res_ready is low the queue fills, the input register holds,
//   and item_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module static_huffman_byte_packer (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire shbp_pkg::in_item_t   item_data,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output shbp_pkg::out_item_t       res_data
);
    import shbp_pkg::*;

    // Input register
    logic      s1_valid_reg;
    in_item_t  s1_data_reg;

    // Bit accumulator
    logic [PEND_W-1:0]     pend_bits_reg, pend_bits_next;
    logic [PEND_CNT_W-1:0] pend_cnt_reg,  pend_cnt_next;

    // Result queue, entry 0 is the head
    out_item_t q_reg [2];
    out_item_t q_next [2];
    logic [1:0] q_cnt_reg, q_cnt_next;

    // Encode path
    code_t              code;
    logic [PEND_W-1:0]  acc;
    logic [ACC_W-1:0]   combined;
    logic [ACC_W-1:0]   remain;
    logic [4:0]         total;
    logic [1:0]         n_push;
    out_item_t          push0, push1;
    logic [PEND_W-1:0]  enc_bits;
    logic [PEND_CNT_W-1:0] enc_cnt;

    logic       pop;
    logic       s1_fire;
    logic [1:0] cnt_after_pop;
    logic [2:0] fill_after;

    // Encode the item held in the input register
    always_comb
    begin
        code     = code_lookup(s1_data_reg.symbol_char);
        acc      = pend_bits_reg & (7'h7F >> (3'd7 - pend_cnt_reg));
        combined = {{CODE_MAX_LEN{1'b0}}, acc}
                 | ({{PEND_W{1'b0}}, code.bits} << pend_cnt_reg);
        total    = {2'b00, pend_cnt_reg} + {1'b0, code.len};
        remain   = '0;
        n_push   = 2'd0;
        push0    = '0;
        push1    = '0;
        enc_bits = acc;
        enc_cnt  = pend_cnt_reg;

        unique case (s1_data_reg.kind)
            KIND_FLUSH:
            begin
                if (pend_cnt_reg != '0)
                begin
                    n_push = 2'd1;
                    push0  = '{out_byte: {1'b0, acc}, byte_valid: 1'b1,
                               symbol_unknown: 1'b0, run_last: 1'b1};
                end
                enc_bits = '0;
                enc_cnt  = '0;
            end
            KIND_SYMBOL:
            begin
                if (!code.known)
                begin
                    n_push = 2'd1;
                    push0  = '{out_byte: 8'h00, byte_valid: 1'b0,
                               symbol_unknown: 1'b1, run_last: 1'b1};
                end
                else
                begin
                    if (total[4])
                        n_push = 2'd2;
                    else if (total[3])
                        n_push = 2'd1;
                    else
                        n_push = 2'd0;
                    push0 = '{out_byte: combined[7:0], byte_valid: 1'b1,
                              symbol_unknown: 1'b0, run_last: (n_push == 2'd1)};
                    push1 = '{out_byte: combined[15:8], byte_valid: 1'b1,
                              symbol_unknown: 1'b0, run_last: 1'b1};
                    remain   = combined >> {n_push, 3'b000};
                    enc_bits = remain[PEND_W-1:0];
                    enc_cnt  = total[PEND_CNT_W-1:0];
                end
            end
            default:
            begin
                n_push = 2'd0;
            end
        endcase
    end

    // Handshake: advance the input register when the queue has room
    always_comb
    begin
        pop           = (q_cnt_reg != 2'd0) && res_ready;
        cnt_after_pop = q_cnt_reg - {1'b0, pop};
        fill_after    = {1'b0, cnt_after_pop} + {1'b0, n_push};
        s1_fire       = s1_valid_reg && (fill_after <= 3'd2);
        item_ready    = !s1_valid_reg || s1_fire;
        res_valid     = (q_cnt_reg != 2'd0);
        res_data      = q_reg[0];
    end

    // Queue update: drop the head on a transfer, then append new results
    always_comb
    begin
        q_next[0]  = q_reg[0];
        q_next[1]  = q_reg[1];
        q_cnt_next = cnt_after_pop;
        if (pop)
            q_next[0] = q_reg[1];
        if (s1_fire)
        begin
            q_cnt_next = fill_after[1:0];
            if (n_push == 2'd2)
            begin
                q_next[0] = push0;
                q_next[1] = push1;
            end
            else if (n_push == 2'd1)
            begin
                if (cnt_after_pop == 2'd0)
                    q_next[0] = push0;
                else
                    q_next[1] = push0;
            end
        end
    end

    // Accumulator next value
    always_comb
    begin
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        if (s1_fire)
        begin
            pend_bits_next = enc_bits;
            pend_cnt_next  = enc_cnt;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            q_cnt_reg     <= 2'd0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end
        else
        begin
            if (item_ready)
                s1_valid_reg <= item_valid;
            q_cnt_reg     <= q_cnt_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            s1_data_reg <= item_data;
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

endmodule

`default_nettype wire

>>> hdl/shbp_checker.sv
// ----------------------------------------------------------------------------
// shbp_checker
// Port-level checks on the result channel of the byte packer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module shbp_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                res_valid,
    input wire logic                res_ready,
    input wire shbp_pkg::out_item_t res_data
);
    import shbp_pkg::*;

    // A stalled result holds its place
    `ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_data))

    // Unknown marker carries no byte and closes its item
    `ASSERT_IMPLIES(a_unknown_form, clk, rst_n, res_valid && res_data.symbol_unknown, !res_data.byte_valid && res_data.run_last && (res_data.out_byte == 8'h00))

    // Every result is either a byte or an unknown marker
    `ASSERT_IMPLIES(a_kind_excl, clk, rst_n, res_valid, res_data.byte_valid != res_data.symbol_unknown)

    // A non-final byte is always followed by another result
    `ASSERT_NEXT(a_run_cont, clk, rst_n, res_valid && res_ready && !res_data.run_last, res_valid)

endmodule

bind static_huffman_byte_packer shbp_checker u_shbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);

`default_nettype wire

>>> test/shbp_byte_checker.sv
// ----------------------------------------------------------------------------
// shbp_byte_checker
// Watches the item and result channels of the prefix-code byte packer. It
// keeps its own bit accumulator, works out the bytes that each accepted item
// must produce, and compares every result transfer with the oldest one due.
// ----------------------------------------------------------------------------
module shbp_byte_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_ready,
    input  shbp_pkg::in_item_t  item_data,
    input  logic                res_valid,
    input  logic                res_ready,
    input  shbp_pkg::out_item_t res_data,
    output int                  fail_count,
    output int                  results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import shbp_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Pending code bits, oldest in bit 0
    logic [6:0] held_bits  = '0;
    logic [2:0] held_count = '0;
    out_item_t  bytes_due[$];
    int         fails = 0;

    // Code of each character, first bit first; empty when it has no code
    function automatic string code_of(input logic [7:0] ch);
        case (ch)
            "a": return "100";
            "b": return "11011000";
            "c": return "1101100100";
            "d": return "1101000";
            "e": return "0100";
            "f": return "1101101";
            "g": return "1101001";
            "h": return "000011";
            "i": return "011";
            "j": return "110111";
            "k": return "1010";
            "l": return "1100";
            "m": return "10110";
            "n": return "0010";
            "o": return "0101";
            "p": return "10111";
            "q": return "110110010101";
            "r": return "00000";
            "s": return "0001";
            "t": return "111";
            "u": return "0011";
            "v": return "000010";
            "w": return "110110010100";
            "x": return "1101100101100";
            "y": return "110101";
            "z": return "110110010111";
            " ": return "110110011";
            "0": return "101";
            "1": return "011";
            "2": return "0001";
            "3": return "0010";
            "4": return "0011";
            "5": return "0000";
            "6": return "0100";
            "7": return "0101";
            "8": return "1000";
            "9": return "10010";
            ",": return "11";
            default: return "";
        endcase
    endfunction

    // Append the item's bits and queue every byte it completes
    task automatic encode_item(input in_item_t it);
        string       code;
        logic [19:0] acc;
        int          cnt;
        int          nbytes;
        out_item_t   r;
        acc = '0;
        cnt = held_count;
        for (int i = 0; i < cnt; i++)
        begin
            acc[i] = held_bits[i];
        end
        if (it.kind == KIND_FLUSH)
        begin
            // Pad the partial byte with zeros, queue nothing if empty
            if (cnt > 0)
            begin
                r = {acc[7:0], 1'b1, 1'b0, 1'b1};
                bytes_due.insert(bytes_due.size(), r);
            end
            held_bits  = '0;
            held_count = '0;
        end
        else
        begin
            code = code_of(it.symbol_char);
            if (code.len() == 0)
            begin
                // Unknown character: marker only, accumulator untouched
                r = {8'h00, 1'b0, 1'b1, 1'b1};
                bytes_due.insert(bytes_due.size(), r);
            end
            else
            begin
                for (int i = 0; i < code.len(); i++)
                begin
                    acc[cnt] = (code[i] == "1");
                    cnt++;
                end
                nbytes = cnt / 8;
                for (int k = 0; k < nbytes; k++)
                begin
                    r = {acc[8*k +: 8], 1'b1, 1'b0, (k == nbytes - 1) ? 1'b1 : 1'b0};
                    bytes_due.insert(bytes_due.size(), r);
                end
                acc        = acc >> (8 * nbytes);
                held_bits  = acc[6:0];
                held_count = 3'(cnt % 8);
            end
        end
    endtask

    // Compare one result transfer with the oldest byte due
    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (bytes_due.size() == 0)
        begin
            fails++;
            if (fails <= REPORT_LIMIT)
                $display("%0t: result with nothing due: byte=%h valid=%b unknown=%b last=%b",
                         $realtime, got.out_byte, got.byte_valid, got.symbol_unknown,
                         got.run_last);
        end
        else
        begin
            want = bytes_due.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.symbol_unknown !== want.symbol_unknown || got.run_last !== want.run_last)
            begin
                fails++;
                if (fails <= REPORT_LIMIT)
                    $display("%0t: mismatch: byte=%h/%h valid=%b/%b unknown=%b/%b last=%b/%b %s",
                             $realtime, got.out_byte, want.out_byte, got.byte_valid,
                             want.byte_valid, got.symbol_unknown, want.symbol_unknown,
                             got.run_last, want.run_last, "(actual/expected)");
            end
        end
    endtask

    // Sample both channels at each rising edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            held_bits  = '0;
            held_count = '0;
            bytes_due.delete();
        end
        else
        begin
            if (item_valid && item_ready)
                encode_item(item_data);
            if (res_valid && res_ready)
                check_result(res_data);
        end
        results_due <= bytes_due.size();
        fail_count  <= fails;
    end

endmodule

>>> test/static_huffman_byte_packer_test.sv
// ----------------------------------------------------------------------------
// static_huffman_byte_packer_test
// Drives characters and flushes into the prefix-code byte packer: a directed
// run over code lengths, unknown characters and flushes, then random traffic
// in three idling phases with one long result stall, and gives the verdict.
// ----------------------------------------------------------------------------
module static_huffman_byte_packer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import shbp_pkg::*;

    localparam int CYCLE_LIMIT      = 300000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 12;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    in_item_t  item_data;
    logic      res_valid;
    logic      res_ready = 1'b0;
    out_item_t res_data;
    int        fail_count;
    int        results_due;

    int        send_idle_pct = 35;
    int        recv_idle_pct = 64;
    logic      long_hold     = 1'b0;
    logic      hold_taken    = 1'b0;
    int        hold_left     = 0;
    int        cycle_count   = 0;
    string     coded_chars   = "abcdefghijklmnopqrstuvwxyz 0123456789,";

    static_huffman_byte_packer uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_data  (item_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    shbp_byte_checker u_byte_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item_data   (item_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: one long hold when asked, random stalls otherwise
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res_ready <= 1'b0;
        end
        else if (long_hold && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD_CYCLES;
            res_ready  <= 1'b0;
        end
        else
            res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one item after a random gap, hold it until its transfer
    task automatic offer(input kind_t kind, input logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_data  <= {kind, ch};
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
    endtask

    // Mostly coded characters, some raw bytes and flushes
    task automatic random_items(input int count);
        int         pick;
        logic [7:0] ch;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            ch   = 8'($urandom_range(255));
            if (pick < 7)
                offer(KIND_FLUSH, ch);
            else if (pick < 15)
                offer(KIND_SYMBOL, ch);
            else
                offer(KIND_SYMBOL, coded_chars[$urandom_range(37)]);
        end
    endtask

    initial
    begin : stimulus
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item_data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Flush on empty, short code, padded partial byte
        offer(KIND_FLUSH, 8'h00);
        offer(KIND_SYMBOL, "a");
        offer(KIND_FLUSH, 8'h00);
        // Longest codes: one byte, then two bytes from one item
        offer(KIND_SYMBOL, "x");
        offer(KIND_SYMBOL, "x");
        offer(KIND_SYMBOL, "q");
        offer(KIND_SYMBOL, "w");
        offer(KIND_SYMBOL, "z");
        offer(KIND_SYMBOL, "c");
        offer(KIND_SYMBOL, " ");
        offer(KIND_SYMBOL, ",");
        offer(KIND_SYMBOL, ",");
        offer(KIND_SYMBOL, "9");
        // Characters with no code, both ends of the byte range
        offer(KIND_SYMBOL, 8'h00);
        offer(KIND_SYMBOL, 8'hFF);
        offer(KIND_SYMBOL, "A");
        offer(KIND_SYMBOL, 8'h80);
        offer(KIND_SYMBOL, "b");
        offer(KIND_FLUSH, 8'hFF);
        offer(KIND_FLUSH, 8'h00);
        offer(KIND_SYMBOL, "0");
        offer(KIND_SYMBOL, "8");
        offer(KIND_SYMBOL, "t");
        offer(KIND_FLUSH, 8'h5A);

        // Sender idles less than the receiver
        random_items(600);

        // Swap the idling
        send_idle_pct <= 64;
        recv_idle_pct <= 35;
        random_items(600);

        // No idling, with one long result stall to back up the input
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        long_hold     <= 1'b1;
        random_items(550);
        item_valid <= 1'b0;

        // Drain what is still due, then let the pipeline settle
        do @(posedge clk); while (results_due != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
